### rtl/core/stot_pkg.sv
// Shared types and constants for the station table.
// No dependencies; imported by stot_table and station_table_oldest_replace.
`timescale 1ns / 1ps

package stot_pkg;

  localparam int unsigned MacW        = 48;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned LevelW      = 8;
  localparam int unsigned SlotW       = 4;
  localparam int unsigned DefEntries  = 16;
  localparam int unsigned MaxResults  = 16;
  localparam logic [TimeW-1:0] StaleReset = 32'd10000000;

  // command codes
  localparam logic CmdObserve = 1'b0;
  localparam logic CmdList    = 1'b1;

  // one table entry as held in the memory
  typedef struct packed {
    logic [MacW-1:0]          mac;
    logic [TimeW-1:0]         seen;
    logic signed [LevelW-1:0] level;
  } entry_t;

endpackage

### rtl/core/stot_table.sv
// Station table storage: one-port-write, one-port-read synchronous memory.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on stot_pkg.
`timescale 1ns / 1ps

module stot_table #(
  parameter int unsigned Entries = stot_pkg::DefEntries,
  parameter int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [IdxW-1:0]  wr_addr_i,
  input  stot_pkg::entry_t wr_data_i,
  input  logic [IdxW-1:0]  rd_addr_i,
  output stot_pkg::entry_t rd_data_o
);
  import stot_pkg::*;

  entry_t              mem [Entries];
  entry_t              rdata_q;
  logic [Entries-1:0]  vld_q;
  logic                rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rdata_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rvld_q <= vld_q[rd_addr_i];
    end
  end

  // never-written entries read as the reset value
  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

### rtl/core/station_table_oldest_replace.sv
// Top level of the station table with oldest-entry replacement.
// Depends on stot_pkg and stot_table.
`timescale 1ns / 1ps

// Keeps Entries recently heard stations (MAC, last-heard microsecond time,
// last signal level), all zero after reset. An observe transaction refreshes
// the highest-numbered entry holding its MAC, or else overwrites the entry
// with the strictly greatest age (now minus stored time, wrapping, unsigned;
// lowest index wins a tie) and returns one result naming the slot. Observe
// transactions flagged short_report are dropped with no result. A list
// transaction returns every entry whose age is at most stale_limit in index
// order (at most 16, last one flagged), or one result with valid_res 0, last
// set, all else zero, when none qualifies. Items are handled one at a time:
// accept, one table read per entry through the single read port, one write or
// flush step; the scan and the final step may wait on result-side stalls, and
// a dropped short report ends at accept. A finished result waits in the output
// register while the next item is accepted. stale_limit may only be written
// while the block is idle; the write port is always ready.

module station_table_oldest_replace #(
  parameter int unsigned Entries = stot_pkg::DefEntries
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [stot_pkg::TimeW-1:0]          cfg_data_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic [stot_pkg::MacW-1:0]           station_mac_i,
  input  logic signed [stot_pkg::LevelW-1:0]  signal_level_i,
  input  logic [stot_pkg::TimeW-1:0]          now_us_i,
  input  logic                                short_report_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [stot_pkg::SlotW-1:0]          slot_o,
  output logic [stot_pkg::MacW-1:0]           entry_mac_o,
  output logic [stot_pkg::TimeW-1:0]          entry_age_o,
  output logic signed [stot_pkg::LevelW-1:0]  entry_level_o,
  output logic                                valid_res_o,
  output logic                                last_o
);
  import stot_pkg::*;

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned NW   = $clog2(MaxResults + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state_q, state_d;

  // captured item
  logic                     cmd_q;
  logic [MacW-1:0]          mac_q;
  logic signed [LevelW-1:0] lvl_q;
  logic [TimeW-1:0]         now_q;

  // scan position: index of the entry whose read data is presented now
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] rd_addr;

  // observe search
  logic [TimeW-1:0] best_q, best_d;
  logic [IdxW-1:0]  pick_q, pick_d;

  // list: one result held back so the final one can be flagged last
  logic             pend_vld_q, pend_vld_d;
  logic [IdxW-1:0]  pend_idx_q, pend_idx_d;
  entry_t           pend_q, pend_d;
  logic [TimeW-1:0] pend_age_q, pend_age_d;
  logic [NW-1:0]    n_q, n_d;

  logic [TimeW-1:0] limit_q;

  // output register
  logic                     out_valid_q;
  logic [SlotW-1:0]         o_slot_q, o_slot_d;
  logic [MacW-1:0]          o_mac_q, o_mac_d;
  logic [TimeW-1:0]         o_age_q, o_age_d;
  logic signed [LevelW-1:0] o_lvl_q, o_lvl_d;
  logic                     o_vres_q, o_vres_d;
  logic                     o_last_q, o_last_d;
  logic                     out_load;
  logic                     out_free;

  // table access
  entry_t           cur;
  entry_t           wr_data;
  logic             wr_en;
  logic [TimeW-1:0] age;
  logic             advance;
  logic             qual;
  logic             accept;

  function automatic logic [SlotW-1:0] to_slot(logic [IdxW-1:0] idx);
    logic [IdxW+SlotW-1:0] wide;
    wide = {{SlotW{1'b0}}, idx};
    return wide[SlotW-1:0];
  endfunction

  stot_table #(
    .Entries (Entries),
    .IdxW    (IdxW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (pick_q),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (cur)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign age  = now_q - cur.seen;
  assign qual = (age <= limit_q) && (n_q < NW'(MaxResults));

  assign wr_data.mac   = mac_q;
  assign wr_data.seen  = now_q;
  assign wr_data.level = lvl_q;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    best_d     = best_q;
    pick_d     = pick_q;
    pend_vld_d = pend_vld_q;
    pend_idx_d = pend_idx_q;
    pend_d     = pend_q;
    pend_age_d = pend_age_q;
    n_d        = n_q;
    advance    = 1'b1;
    wr_en      = 1'b0;
    out_load   = 1'b0;
    o_slot_d   = o_slot_q;
    o_mac_d    = o_mac_q;
    o_age_d    = o_age_q;
    o_lvl_d    = o_lvl_q;
    o_vres_d   = o_vres_q;
    o_last_d   = o_last_q;
    rd_addr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept && !(cmd_i == CmdObserve && short_report_i)) begin
          state_d    = S_SCAN;
          idx_d      = '0;
          best_d     = '0;
          pick_d     = '0;
          pend_vld_d = 1'b0;
          n_d        = '0;
        end
      end
      S_SCAN: begin
        if (cmd_q == CmdObserve) begin
          if (age > best_q) begin
            best_d = age;
            pick_d = idx_q;
          end
          // a match wins over any age; a later match overrides
          if (cur.mac == mac_q) begin
            pick_d = idx_q;
            best_d = '1;
          end
        end else if (qual) begin
          if (pend_vld_q && !out_free) begin
            advance = 1'b0;
          end else begin
            if (pend_vld_q) begin
              out_load = 1'b1;
              o_slot_d = to_slot(pend_idx_q);
              o_mac_d  = pend_q.mac;
              o_age_d  = pend_age_q;
              o_lvl_d  = pend_q.level;
              o_vres_d = 1'b1;
              o_last_d = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_idx_d = idx_q;
            pend_d     = cur;
            pend_age_d = age;
            n_d        = n_q + NW'(1);
          end
        end

        if (advance) begin
          if (idx_q == LastIdx) begin
            state_d = (cmd_q == CmdObserve) ? S_WRITE : S_FLUSH;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            rd_addr = idx_q + IdxW'(1);
          end
        end else begin
          rd_addr = idx_q;
        end
      end
      S_WRITE: begin
        if (out_free) begin
          wr_en    = 1'b1;
          out_load = 1'b1;
          o_slot_d = to_slot(pick_q);
          o_mac_d  = mac_q;
          o_age_d  = '0;
          o_lvl_d  = lvl_q;
          o_vres_d = 1'b1;
          o_last_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          o_last_d = 1'b1;
          if (pend_vld_q) begin
            o_slot_d = to_slot(pend_idx_q);
            o_mac_d  = pend_q.mac;
            o_age_d  = pend_age_q;
            o_lvl_d  = pend_q.level;
            o_vres_d = 1'b1;
          end else begin
            // empty list marker
            o_slot_d = '0;
            o_mac_d  = '0;
            o_age_d  = '0;
            o_lvl_d  = '0;
            o_vres_d = 1'b0;
          end
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_vld_q  <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      limit_q     <= StaleReset;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      n_q        <= n_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      mac_q <= station_mac_i;
      lvl_q <= signal_level_i;
      now_q <= now_us_i;
    end
    idx_q      <= idx_d;
    best_q     <= best_d;
    pick_q     <= pick_d;
    pend_idx_q <= pend_idx_d;
    pend_q     <= pend_d;
    pend_age_q <= pend_age_d;
    o_slot_q   <= o_slot_d;
    o_mac_q    <= o_mac_d;
    o_age_q    <= o_age_d;
    o_lvl_q    <= o_lvl_d;
    o_vres_q   <= o_vres_d;
    o_last_q   <= o_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign slot_o        = o_slot_q;
  assign entry_mac_o   = o_mac_q;
  assign entry_age_o   = o_age_q;
  assign entry_level_o = o_lvl_q;
  assign valid_res_o   = o_vres_q;
  assign last_o        = o_last_q;

  // table writes belong to observe items only
  a_write_observe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> (cmd_q == CmdObserve))
    else $error("table write outside an observe item");

  // held-back list result only exists during a list item
  a_pend_list : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (cmd_q == CmdList))
    else $error("pending list result during observe");

  // the empty marker is always the final result
  a_empty_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> last_o)
    else $error("empty marker not flagged last");

  // list result count never exceeds the cap
  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MaxResults))
    else $error("list result count over cap");

  // a new result never overwrites one still waiting
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(entry_mac_o))
    else $error("waiting result overwritten");

endmodule

### bench/station_table_oldest_replace_tb.sv
// Self-checking bench for station_table_oldest_replace: directed and random observe/list
// transactions against a scoreboard class that mirrors the station table.
// Depends on stot_pkg and the station_table_oldest_replace RTL.
`timescale 1ns / 1ps

module station_table_oldest_replace_tb;
  import stot_pkg::*;

  localparam int unsigned Slots         = DefEntries;
  localparam int unsigned PoolSize      = 24;   // more MACs than slots, forces eviction
  localparam int unsigned SettleCycles  = 40;   // outlasts the processing of one item
  localparam int unsigned QuietLimit    = 2000; // cycles with no transaction at all
  localparam int unsigned ItemsPerPhase = 45;
  localparam int unsigned RandPhases    = 8;
  localparam int unsigned ShowLimit     = 200;  // keep the log readable on a bad run

  // one input transaction, field for field as on the ports
  typedef struct packed {
    logic                     cmd;
    logic [MacW-1:0]          mac;
    logic signed [LevelW-1:0] level;
    logic [TimeW-1:0]         now;
    logic                     short_rpt;
  } frame_item_t;

  // one output transaction
  typedef struct packed {
    logic [SlotW-1:0]         slot;
    logic [MacW-1:0]          mac;
    logic [TimeW-1:0]         age;
    logic signed [LevelW-1:0] level;
    logic                     valid_res;
    logic                     last;
  } station_report_t;

  // Scoreboard: private copy of the station table and of stale_limit, plus the
  // queue of reports the block still owes us.
  class station_ledger;
    logic [MacW-1:0]          mac_tab   [Slots];
    logic [TimeW-1:0]         heard_tab [Slots];
    logic signed [LevelW-1:0] level_tab [Slots];
    logic [TimeW-1:0]         age_limit;
    station_report_t          due_reports [$];
    int unsigned              errors;
    int unsigned              shown;

    function void clear();
      foreach (mac_tab[i]) begin
        mac_tab[i]   = '0;
        heard_tab[i] = '0;
        level_tab[i] = '0;
      end
      age_limit = StaleReset;
      due_reports.delete();
      errors = 0;
      shown  = 0;
    endfunction

    function void set_limit(logic [TimeW-1:0] value);
      age_limit = value;
    endfunction

    function int pending();
      return due_reports.size();
    endfunction

    // Note an accepted input transaction and queue the reports it causes.
    function void absorb_item(frame_item_t it);
      logic [TimeW-1:0] age;
      logic [TimeW-1:0] best;
      int               pick;
      int               live;
      int               n;
      station_report_t  rep;
      if (it.cmd == CmdObserve) begin
        if (it.short_rpt) return;  // truncated frame report: dropped silently
        best = '0;
        pick = 0;
        // oldest wins on strictly greater age; a MAC hit overrides and pins
        // best at all ones, so a later hit (higher index) still takes over
        for (int i = 0; i < Slots; i++) begin
          age = it.now - heard_tab[i];
          if (age > best) begin
            best = age;
            pick = i;
          end
          if (mac_tab[i] == it.mac) begin
            pick = i;
            best = '1;
          end
        end
        mac_tab[pick]   = it.mac;
        heard_tab[pick] = it.now;
        level_tab[pick] = it.level;
        rep.slot      = SlotW'(pick);
        rep.mac       = it.mac;
        rep.age       = '0;
        rep.level     = it.level;
        rep.valid_res = 1'b1;
        rep.last      = 1'b1;
        due_reports.push_back(rep);
      end else begin
        // first pass counts live entries so the final one can carry last
        live = 0;
        for (int i = 0; i < Slots; i++) begin
          age = it.now - heard_tab[i];
          if (age <= age_limit && live < MaxResults) live++;
        end
        if (live == 0) begin
          rep = '0;
          rep.last = 1'b1;
          due_reports.push_back(rep);
        end else begin
          n = 0;
          for (int i = 0; i < Slots && n < live; i++) begin
            age = it.now - heard_tab[i];
            if (age <= age_limit) begin
              n++;
              rep.slot      = SlotW'(i);
              rep.mac       = mac_tab[i];
              rep.age       = age;
              rep.level     = level_tab[i];
              rep.valid_res = 1'b1;
              rep.last      = (n == live);
              due_reports.push_back(rep);
            end
          end
        end
      end
    endfunction

    function void field_diff(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        if (shown < ShowLimit) begin
          shown++;
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
      end
    endfunction

    // Compare one accepted output transaction with the oldest expectation.
    function void match_report(station_report_t got);
      station_report_t want;
      if (due_reports.size() == 0) begin
        errors++;
        if (shown < ShowLimit) begin
          shown++;
          $display("%0t: unexpected result, expected none, actual slot %0h mac %0h",
                   $time, got.slot, got.mac);
        end
        return;
      end
      want = due_reports.pop_front();
      field_diff("slot", 64'(want.slot), 64'(got.slot));
      field_diff("entry_mac", 64'(want.mac), 64'(got.mac));
      field_diff("entry_age", 64'(want.age), 64'(got.age));
      field_diff("entry_level", 64'($unsigned(want.level)), 64'($unsigned(got.level)));
      field_diff("valid_res", 64'(want.valid_res), 64'(got.valid_res));
      field_diff("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  // All inputs start at a known value at time zero.
  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_valid_i    = 1'b0;
  logic                     cfg_ready_o;
  logic [TimeW-1:0]         cfg_data_i     = '0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic                     cmd_i          = CmdObserve;
  logic [MacW-1:0]          station_mac_i  = '0;
  logic signed [LevelW-1:0] signal_level_i = '0;
  logic [TimeW-1:0]         now_us_i       = '0;
  logic                     short_report_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic [SlotW-1:0]         slot_o;
  logic [MacW-1:0]          entry_mac_o;
  logic [TimeW-1:0]         entry_age_o;
  logic signed [LevelW-1:0] entry_level_o;
  logic                     valid_res_o;
  logic                     last_o;

  station_ledger ledger;

  // Per side: 0 = input, 1 = result. A side in calm mode never idles; the mode
  // flips now and then so long back-to-back stretches alternate with stalls.
  bit calm_side [2];

  station_table_oldest_replace #(
    .Entries(Slots)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .station_mac_i  (station_mac_i),
    .signal_level_i (signal_level_i),
    .now_us_i       (now_us_i),
    .short_report_i (short_report_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .slot_o         (slot_o),
    .entry_mac_o    (entry_mac_o),
    .entry_age_o    (entry_age_o),
    .entry_level_o  (entry_level_o),
    .valid_res_o    (valid_res_o),
    .last_o         (last_o)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  function automatic int draw_gap(int side);
    if ($urandom_range(0, 19) == 0) calm_side[side] = ~calm_side[side];
    return calm_side[side] ? 0 : int'($urandom_range(0, 11));
  endfunction

  function automatic frame_item_t mk_item(logic cmd, logic [MacW-1:0] mac,
                                          logic [LevelW-1:0] level,
                                          logic [TimeW-1:0] now, logic short_rpt);
    frame_item_t it;
    it.cmd       = cmd;
    it.mac       = mac;
    it.level     = level;
    it.now       = now;
    it.short_rpt = short_rpt;
    return it;
  endfunction

  // Present one input transaction and return in the step it is accepted.
  // Valid is left high; the next call lowers it only if it draws a gap, so
  // valid never gets two assignments in one step.
  task automatic send_item(frame_item_t it);
    int gap;
    gap = draw_gap(0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= it.cmd;
    station_mac_i  <= it.mac;
    signal_level_i <= it.level;
    now_us_i       <= it.now;
    short_report_i <= it.short_rpt;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    ledger.absorb_item(it);
  endtask

  // Stop sending, let every owed report come out, then let the block settle;
  // a dropped short report owes nothing and needs no table scan.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Only called with the block idle, see quiesce().
  task automatic write_limit(logic [TimeW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    ledger.set_limit(value);
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: random ready stalls, independent of valid.
  initial begin : result_sink
    int gap;
    forever begin
      gap = draw_gap(1);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
    end
  end

  // Sample at the edge; values read here are the ones from before the edge.
  always @(posedge clk_i) begin : result_monitor
    station_report_t got;
    if (out_valid_o === 1'b1 && out_ready_i) begin
      got.slot      = slot_o;
      got.mac       = entry_mac_o;
      got.age       = entry_age_o;
      got.level     = entry_level_o;
      got.valid_res = valid_res_o;
      got.last      = last_o;
      ledger.match_report(got);
    end
  end

  // Hang detector: any cycle without a single transaction on any channel counts.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [MacW-1:0]  mac_pool [PoolSize];
    logic [TimeW-1:0] limit;
    logic [TimeW-1:0] clock_us;
    logic [MacW-1:0]  mac;
    int unsigned      roll;
    int unsigned      counted;
    ledger = new();
    ledger.clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed, reset stale limit ---
    // fresh table, all ages zero: list returns all sixteen zero entries
    send_item(mk_item(CmdList, '0, '0, '0, 1'b0));
    // every age zero, MAC absent: entry 0 is the victim
    send_item(mk_item(CmdObserve, 48'h0000_0000_0123, 8'h00, '0, 1'b0));
    // MAC zero still sits in entries 1..15: highest one is refreshed
    send_item(mk_item(CmdObserve, '0, 8'h05, '0, 1'b0));
    // age tie across entries: lowest index wins
    send_item(mk_item(CmdObserve, '1, 8'h80, 32'd100, 1'b0));
    send_item(mk_item(CmdObserve, 48'h8000_0000_0000, 8'h7f, 32'd100, 1'b0));
    // refresh of an existing station
    send_item(mk_item(CmdObserve, '1, 8'h01, 32'd150, 1'b0));
    // short report: no table change, no result
    send_item(mk_item(CmdObserve, 48'hAAAA_AAAA_AAAA, 8'hff, '1, 1'b1));
    send_item(mk_item(CmdList, '0, '0, 32'd200, 1'b0));
    // every age far past the limit: the empty-list marker
    send_item(mk_item(CmdList, '1, 8'h7f, '1, 1'b0));
    send_item(mk_item(CmdObserve, 48'h5555_5555_5555, 8'h55, 32'hFFFF_FFF0, 1'b0));
    // time wraps past zero
    send_item(mk_item(CmdObserve, 48'hAAAA_AAAA_AAAA, 8'hAA, 32'd5, 1'b0));
    // short_report has no meaning on a list
    send_item(mk_item(CmdList, 48'h1234_5678_9abc, 8'h80, 32'd10, 1'b1));

    // --- limit zero: only entries heard right now are live ---
    quiesce();
    write_limit('0);
    send_item(mk_item(CmdList, '0, '0, 32'd11, 1'b0));
    send_item(mk_item(CmdObserve, 48'h0F0F_0F0F_0F0F, 8'h3c, 32'd11, 1'b0));
    send_item(mk_item(CmdList, '0, '0, 32'd11, 1'b0));

    // --- limit all ones: everything is live ---
    quiesce();
    write_limit('1);
    send_item(mk_item(CmdList, '0, '0, 32'h8000_0000, 1'b0));
    send_item(mk_item(CmdList, '0, '0, '0, 1'b0));

    // --- random phases, each under its own stale limit ---
    for (int phase = 0; phase < RandPhases; phase++) begin
      quiesce();
      case (phase)
        0:       limit = '0;
        1:       limit = '1;
        2:       limit = StaleReset;
        3:       limit = $urandom;
        default: limit = $urandom_range(0, 400 * phase);
      endcase
      write_limit(limit);
      // one phase starts just below the wrap point of the time base
      clock_us = (phase == 2) ? 32'hFFFF_F000 : TimeW'($urandom);
      foreach (mac_pool[k]) mac_pool[k] = MacW'({$urandom, $urandom});
      mac_pool[0] = '0;
      mac_pool[1] = '1;
      counted = 0;
      while (counted < ItemsPerPhase) begin
        // time mostly creeps forward, sometimes stands still
        if ($urandom_range(0, 3) != 0) clock_us = clock_us + TimeW'($urandom_range(1, 300));
        roll = $urandom_range(0, 99);
        mac  = (roll < 6) ? MacW'({$urandom, $urandom})
                          : mac_pool[$urandom_range(0, PoolSize - 1)];
        if (roll < 60) begin
          send_item(mk_item(CmdObserve, mac, LevelW'($urandom), clock_us, 1'b0));
          counted++;
        end else if (roll < 80) begin
          send_item(mk_item(CmdList, MacW'({$urandom, $urandom}), LevelW'($urandom),
                            clock_us, 1'($urandom)));
          counted++;
        end else if (roll < 90) begin
          // noise: truncated reports with arbitrary content
          send_item(mk_item(CmdObserve, mac, LevelW'($urandom), TimeW'($urandom), 1'b1));
        end else if (roll < 95) begin
          // time jumps anywhere
          send_item(mk_item(CmdObserve, mac, LevelW'($urandom), TimeW'($urandom), 1'b0));
          counted++;
        end else begin
          // time slightly in the past: ages wrap to huge values
          send_item(mk_item(CmdObserve, mac, LevelW'($urandom),
                            clock_us - TimeW'($urandom_range(1, 2000)), 1'b0));
          counted++;
        end
      end
    end

    quiesce();
    if (ledger.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### station_table_oldest_replace.f
rtl/core/stot_pkg.sv
rtl/core/stot_table.sv
rtl/core/station_table_oldest_replace.sv
bench/station_table_oldest_replace_tb.sv
